// ===== src/cbq_pkg.sv =====
// ----------------------------------------------------------------------------
// cbq_pkg: shared types and constants of the cascaded biquad low-pass mix
// Register indexes, sequencer states, step codes and fixed field widths.
// ----------------------------------------------------------------------------
package cbq_pkg;

  localparam int COEF_W    = 24;
  localparam int MUL_A_W   = COEF_W + 1;
  localparam int MIX_W     = 17;
  localparam int MIX_SHIFT = 16;
  localparam int CNT_CFG_W = 4;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = COEF_W;

  localparam logic [MIX_W-1:0] MIX_ONE = MIX_W'(65536);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_B0,
    REG_B1,
    REG_B2,
    REG_A1,
    REG_A2,
    REG_WET_MIX,
    REG_STAGE_COUNT,
    REG_FILTER_ON
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_MIX,
    ST_OUT
  } state_e;

  // In ST_MIX only TAP_X0 (wet), TAP_X1 (dry) and TAP_X2 (finish) are used.
  typedef enum logic [2:0] {
    TAP_X0,
    TAP_X1,
    TAP_X2,
    TAP_Y1,
    TAP_Y2,
    TAP_FIN
  } tap_e;

endpackage

// ===== src/cascaded_biquad_lowpass_mix.sv =====
// ----------------------------------------------------------------------------
// cascaded_biquad_lowpass_mix: cascaded direct-form-1 biquad with wet/dry mix
// One sample in, one saturated sample out, through up to MAX_STAGES stages.
// ----------------------------------------------------------------------------
// One shared multiplier with an accumulator, run by a small sequencer, does
// all the work. Each active stage forms five products, then rounds,
// saturates and updates its history, and the blend forms the wet and dry
// products and saturates their sum when the filter is on. in_stall_o is
// high from the transfer of a sample until its result is loaded into the
// output register; a result waiting there does not hold up the next sample.
// Coefficients are signed Q2.22, wet_mix is unsigned Q1.16; write registers
// only while idle.
// ----------------------------------------------------------------------------
module cascaded_biquad_lowpass_mix #(
  parameter int MAX_STAGES     = 8,
  parameter int SAMPLE_BITS    = 24,
  parameter int COEF_FRAC_BITS = 22
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [cbq_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [cbq_pkg::CFG_DAT_W-1:0]      cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic signed [SAMPLE_BITS-1:0]      sample_in_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [SAMPLE_BITS-1:0]      sample_out_o
);

  localparam int SB     = SAMPLE_BITS;
  localparam int STG_W  = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;
  localparam int CNT_W  = $clog2(MAX_STAGES + 1);
  localparam int PROD_W = cbq_pkg::MUL_A_W + SB;
  localparam int ACC_W  = PROD_W + 3;

  localparam logic signed [ACC_W-1:0] SMAX = {{(ACC_W-SB+1){1'b0}}, {(SB-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] SMIN = ~SMAX;
  localparam logic signed [ACC_W-1:0] ROUND_STG = ACC_W'(1) <<< (COEF_FRAC_BITS - 1);
  localparam logic signed [ACC_W-1:0] ROUND_MIX = ACC_W'(1) <<< (cbq_pkg::MIX_SHIFT - 1);

  // configuration
  logic signed [cbq_pkg::COEF_W-1:0]    b0_q, b1_q, b2_q, a1_q, a2_q;
  logic [cbq_pkg::MIX_W-1:0]            wet_q;
  logic [cbq_pkg::CNT_CFG_W-1:0]        stage_count_q;
  logic                                 filter_on_q;

  // stage history
  logic signed [SB-1:0] hist_x1_q [MAX_STAGES];
  logic signed [SB-1:0] hist_x2_q [MAX_STAGES];
  logic signed [SB-1:0] hist_y1_q [MAX_STAGES];
  logic signed [SB-1:0] hist_y2_q [MAX_STAGES];

  // sequencer and datapath
  cbq_pkg::state_e state_q, state_d;
  cbq_pkg::tap_e   tap_q, tap_d;
  logic [STG_W-1:0]         stage_q, stage_d;
  logic [CNT_W-1:0]         n_q, n_d;
  logic signed [SB-1:0]     x_q, x_d;
  logic signed [SB-1:0]     y_q, y_d;
  logic signed [SB-1:0]     res_q, res_d;
  logic signed [ACC_W-1:0]  acc_q, acc_d;
  logic signed [PROD_W-1:0] prod_q, prod_d;
  logic                     neg_q, neg_d;
  logic                     out_valid_q;
  logic signed [SB-1:0]     out_data_q;

  logic                              in_xfer;
  logic                              out_free;
  logic                              hist_we;
  logic                              last_stage;
  logic [CNT_W-1:0]                  n_eff;
  logic [cbq_pkg::MIX_W-1:0]         w_eff;
  logic [cbq_pkg::MIX_W-1:0]         d_eff;
  logic signed [cbq_pkg::MUL_A_W-1:0] mul_a;
  logic signed [SB-1:0]              mul_b;
  logic signed [PROD_W-1:0]          mul_p;
  logic signed [ACC_W-1:0]           prod_term;
  logic signed [ACC_W-1:0]           sum;
  logic signed [ACC_W-1:0]           shifted;
  logic signed [SB-1:0]              sat_val;

  assign in_stall_o   = (state_q != cbq_pkg::ST_IDLE);
  assign in_xfer      = in_valid_i && !in_stall_o;
  assign out_free     = !out_valid_q || !out_stall_i;
  assign out_valid_o  = out_valid_q;
  assign sample_out_o = out_data_q;

  always_comb begin
    if (int'(stage_count_q) > MAX_STAGES) begin
      n_eff = CNT_W'(MAX_STAGES);
    end else begin
      n_eff = CNT_W'(stage_count_q);
    end
  end

  assign w_eff = (wet_q > cbq_pkg::MIX_ONE) ? cbq_pkg::MIX_ONE : wet_q;
  assign d_eff = cbq_pkg::MIX_ONE - w_eff;
  assign last_stage = ((CNT_W'(stage_q) + CNT_W'(1)) == n_q);

  // shared multiplier operand select
  always_comb begin
    mul_a = cbq_pkg::MUL_A_W'(b0_q);
    mul_b = y_q;
    if (state_q == cbq_pkg::ST_MIX) begin
      if (tap_q == cbq_pkg::TAP_X0) begin
        mul_a = signed'(cbq_pkg::MUL_A_W'(w_eff));
        mul_b = y_q;
      end else begin
        mul_a = signed'(cbq_pkg::MUL_A_W'(d_eff));
        mul_b = x_q;
      end
    end else begin
      case (tap_q)
        cbq_pkg::TAP_X0: begin
          mul_a = cbq_pkg::MUL_A_W'(b0_q);
          mul_b = y_q;
        end
        cbq_pkg::TAP_X1: begin
          mul_a = cbq_pkg::MUL_A_W'(b1_q);
          mul_b = hist_x1_q[stage_q];
        end
        cbq_pkg::TAP_X2: begin
          mul_a = cbq_pkg::MUL_A_W'(b2_q);
          mul_b = hist_x2_q[stage_q];
        end
        cbq_pkg::TAP_Y1: begin
          mul_a = cbq_pkg::MUL_A_W'(a1_q);
          mul_b = hist_y1_q[stage_q];
        end
        cbq_pkg::TAP_Y2: begin
          mul_a = cbq_pkg::MUL_A_W'(a2_q);
          mul_b = hist_y2_q[stage_q];
        end
        default: begin
          mul_a = cbq_pkg::MUL_A_W'(b0_q);
          mul_b = y_q;
        end
      endcase
    end
  end

  assign mul_p = mul_a * mul_b;

  // accumulate, round and saturate
  assign prod_term = neg_q ? -ACC_W'(prod_q) : ACC_W'(prod_q);
  assign sum       = acc_q + prod_term;
  assign shifted   = (state_q == cbq_pkg::ST_MIX) ? (sum >>> cbq_pkg::MIX_SHIFT)
                                                  : (sum >>> COEF_FRAC_BITS);

  always_comb begin
    if (shifted > SMAX) begin
      sat_val = SMAX[SB-1:0];
    end else if (shifted < SMIN) begin
      sat_val = SMIN[SB-1:0];
    end else begin
      sat_val = shifted[SB-1:0];
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      cbq_pkg::ST_IDLE: begin
        if (in_xfer) begin
          if (n_eff != '0) begin
            state_d = cbq_pkg::ST_MAC;
          end else if (filter_on_q) begin
            state_d = cbq_pkg::ST_MIX;
          end else begin
            state_d = cbq_pkg::ST_OUT;
          end
        end
      end
      cbq_pkg::ST_MAC: begin
        if (tap_q == cbq_pkg::TAP_FIN && last_stage) begin
          state_d = filter_on_q ? cbq_pkg::ST_MIX : cbq_pkg::ST_OUT;
        end
      end
      cbq_pkg::ST_MIX: begin
        if (tap_q == cbq_pkg::TAP_X2) begin
          state_d = cbq_pkg::ST_OUT;
        end
      end
      cbq_pkg::ST_OUT: begin
        if (out_free) begin
          state_d = cbq_pkg::ST_IDLE;
        end
      end
      default: state_d = cbq_pkg::ST_IDLE;
    endcase
  end

  // datapath controls
  always_comb begin
    tap_d   = tap_q;
    stage_d = stage_q;
    n_d     = n_q;
    x_d     = x_q;
    y_d     = y_q;
    res_d   = res_q;
    acc_d   = acc_q;
    prod_d  = prod_q;
    neg_d   = neg_q;
    hist_we = 1'b0;
    case (state_q)
      cbq_pkg::ST_IDLE: begin
        if (in_xfer) begin
          x_d     = sample_in_i;
          y_d     = sample_in_i;
          res_d   = sample_in_i;
          n_d     = n_eff;
          stage_d = '0;
          tap_d   = cbq_pkg::TAP_X0;
          acc_d   = (n_eff != '0) ? ROUND_STG : ROUND_MIX;
        end
      end
      cbq_pkg::ST_MAC: begin
        if (tap_q != cbq_pkg::TAP_X0) begin
          acc_d = sum;
        end
        if (tap_q != cbq_pkg::TAP_FIN) begin
          prod_d = mul_p;
          neg_d  = (tap_q == cbq_pkg::TAP_Y1) || (tap_q == cbq_pkg::TAP_Y2);
          tap_d  = cbq_pkg::tap_e'(3'(tap_q) + 3'd1);
        end else begin
          hist_we = 1'b1;
          y_d     = sat_val;
          tap_d   = cbq_pkg::TAP_X0;
          if (last_stage) begin
            acc_d = ROUND_MIX;
            res_d = x_q;
          end else begin
            acc_d   = ROUND_STG;
            stage_d = stage_q + STG_W'(1);
          end
        end
      end
      cbq_pkg::ST_MIX: begin
        if (tap_q != cbq_pkg::TAP_X0) begin
          acc_d = sum;
        end
        if (tap_q == cbq_pkg::TAP_X2) begin
          res_d = sat_val;
        end else begin
          prod_d = mul_p;
          neg_d  = 1'b0;
          tap_d  = cbq_pkg::tap_e'(3'(tap_q) + 3'd1);
        end
      end
      cbq_pkg::ST_OUT: begin
        tap_d = cbq_pkg::TAP_X0;
      end
      default: begin
        tap_d = cbq_pkg::TAP_X0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b0_q          <= '0;
      b1_q          <= '0;
      b2_q          <= '0;
      a1_q          <= '0;
      a2_q          <= '0;
      wet_q         <= '0;
      stage_count_q <= '0;
      filter_on_q   <= 1'b0;
    end else if (cfg_we_i) begin
      case (cbq_pkg::cfg_reg_e'(cfg_idx_i))
        cbq_pkg::REG_B0:          b0_q <= cfg_data_i[cbq_pkg::COEF_W-1:0];
        cbq_pkg::REG_B1:          b1_q <= cfg_data_i[cbq_pkg::COEF_W-1:0];
        cbq_pkg::REG_B2:          b2_q <= cfg_data_i[cbq_pkg::COEF_W-1:0];
        cbq_pkg::REG_A1:          a1_q <= cfg_data_i[cbq_pkg::COEF_W-1:0];
        cbq_pkg::REG_A2:          a2_q <= cfg_data_i[cbq_pkg::COEF_W-1:0];
        cbq_pkg::REG_WET_MIX:     wet_q <= cfg_data_i[cbq_pkg::MIX_W-1:0];
        cbq_pkg::REG_STAGE_COUNT: stage_count_q <= cfg_data_i[cbq_pkg::CNT_CFG_W-1:0];
        cbq_pkg::REG_FILTER_ON:   filter_on_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < MAX_STAGES; k++) begin
        hist_x1_q[k] <= '0;
        hist_x2_q[k] <= '0;
        hist_y1_q[k] <= '0;
        hist_y2_q[k] <= '0;
      end
    end else if (hist_we) begin
      hist_x2_q[stage_q] <= hist_x1_q[stage_q];
      hist_x1_q[stage_q] <= y_q;
      hist_y2_q[stage_q] <= hist_y1_q[stage_q];
      hist_y1_q[stage_q] <= sat_val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cbq_pkg::ST_IDLE;
      tap_q   <= cbq_pkg::TAP_X0;
      stage_q <= '0;
      n_q     <= '0;
    end else begin
      state_q <= state_d;
      tap_q   <= tap_d;
      stage_q <= stage_d;
      n_q     <= n_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    y_q    <= y_d;
    res_q  <= res_d;
    acc_q  <= acc_d;
    prod_q <= prod_d;
    neg_q  <= neg_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == cbq_pkg::ST_OUT && out_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == cbq_pkg::ST_OUT && out_free) begin
      out_data_q <= res_q;
    end
  end

  a_stage_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == cbq_pkg::ST_MAC |-> (CNT_W'(stage_q) < n_q))
    else $error("stage index beyond active stage count");

  a_mix_tap_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == cbq_pkg::ST_MIX |->
      (tap_q == cbq_pkg::TAP_X0 || tap_q == cbq_pkg::TAP_X1 || tap_q == cbq_pkg::TAP_X2))
    else $error("blend step out of range");

  a_mix_only_when_on: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == cbq_pkg::ST_MIX |-> filter_on_q)
    else $error("blend entered with filter off");

  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == cbq_pkg::ST_OUT && out_valid_q && out_stall_i) |=>
      (state_q == cbq_pkg::ST_OUT && $stable(out_data_q)))
    else $error("result dropped while output register is full");

endmodule
